[rtl/core/hsort_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the heap_sorter insertion chain.
// No dependencies; imported by hsort_cell and heap_sorter_core.
package hsort_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int SETTLE_W     = $clog2(MAX_ELEMENTS);

	// One slot of the chain: a held element or an element in flight.
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] data;
	} slot_t;

endpackage

[rtl/core/heap_sorter_core.sv]
`timescale 1ns / 1ps
// Top level of the sorter: load/settle/emit control, output register, cell chain.
// Depends on hsort_pkg and hsort_cell.

// heap_sorter_core collects signed 32-bit values, one per input transaction,
// until a transaction marked last_in, then returns them in ascending order
// with last_out on the final result. Up to MAX_ELEMENTS (64) values are kept;
// further values of the same batch are dropped and overflow is set on every
// result of that batch. Values may arrive back to back while loading: each
// value enters a chain of 64 cells and ripples one cell per cycle until it
// finds its place. After the last value the block waits in a settle state for
// values still in flight, then shifts one result per cycle into the output
// register while that register is free or being drained. The next batch may
// start loading while the final result of the previous one still waits.
module heap_sorter_core
	import hsort_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     last_out,
	output logic                     overflow
);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic [SETTLE_W-1:0]      settle_q;
	logic                     drop_q;
	logic                     out_vld_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic                     out_last_q;
	logic                     out_ovf_q;

	logic                     in_fire;
	logic                     has_room;
	logic                     emit_step;
	logic                     shift;
	slot_t                    carry [MAX_ELEMENTS+1];
	slot_t                    slot  [MAX_ELEMENTS+1];
	logic [MAX_ELEMENTS-1:0]  slot_vld;

	assign in_ready  = (state_q == ST_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign has_room  = (count_q < CNT_W'(MAX_ELEMENTS));
	// one result per cycle while the output register is free or being drained
	assign emit_step = (state_q == ST_EMIT) && (!out_vld_q || out_ready);
	assign shift     = emit_step;

	// inject into the head cell; drop once the chain is full
	assign carry[0].vld  = in_fire && has_room;
	assign carry[0].data = value;
	// tail of the chain shifts in nothing
	assign slot[MAX_ELEMENTS] = '0;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		hsort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift),
			.carry_prev (carry[i]),
			.right_slot (slot[i+1]),
			.slot       (slot[i]),
			.carry_next (carry[i+1])
		);
		assign slot_vld[i] = slot[i].vld;
	end

	// control: load, wait for the chain to settle, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			settle_q  <= '0;
			drop_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (last_in) begin
							state_q  <= ST_SETTLE;
							settle_q <= '0;
						end
					end
				end
				ST_SETTLE: begin
					settle_q <= settle_q + SETTLE_W'(1);
					if (settle_q == SETTLE_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_step && count_q == CNT_W'(1)) begin
						// final result taken into the output register: reopen
						state_q <= ST_LOAD;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			if (emit_step) begin
				count_q   <= count_q - CNT_W'(1);
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output payload: hold until taken
	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_data_q <= slot[0].data;
			out_last_q <= (count_q == CNT_W'(1));
			out_ovf_q  <= drop_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign sorted_value = out_data_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

`ifndef NO_ASSERTIONS
	// the head cell always has an element while results remain
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> slot_vld[0])
		else $error("head cell empty during emit");

	// no element ever falls off the end of the chain
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!carry[MAX_ELEMENTS].vld)
		else $error("element passed beyond last cell");

	// after the final result the chain is empty
	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_step && count_q == CNT_W'(1)) |=> (slot_vld == '0))
		else $error("chain not empty after final result");

	// a batch that reaches settle holds at least one and at most the depth
	a_settle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETTLE) |->
			(count_q != '0 && count_q <= CNT_W'(MAX_ELEMENTS)))
		else $error("bad element count at settle");
`endif

endmodule

[rtl/core/hsort_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorting chain: holds the smallest element that reached it; on shift, takes the right slot.
// Depends on hsort_pkg.
module hsort_cell
	import hsort_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t carry_prev,
	input  slot_t right_slot,
	output slot_t slot,
	output slot_t carry_next
);

	logic                     vld_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     pass_vld_q;
	logic signed [DATA_W-1:0] pass_data_q;
	slot_t                    cur;
	slot_t                    keep_n;
	slot_t                    pass_n;

	assign cur.vld  = vld_q;
	assign cur.data = data_q;

	always_comb begin
		keep_n = cur;
		pass_n = '0;
		if (shift) begin
			// emit: advance toward the head of the chain
			keep_n = right_slot;
		end else if (carry_prev.vld) begin
			if (!cur.vld) begin
				keep_n = carry_prev;
			end else if (carry_prev.data < cur.data) begin
				keep_n = carry_prev;
				pass_n = cur;
			end else begin
				pass_n = carry_prev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			pass_vld_q <= 1'b0;
		end else begin
			vld_q      <= keep_n.vld;
			pass_vld_q <= pass_n.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q      <= keep_n.data;
		pass_data_q <= pass_n.data;
	end

	assign slot            = cur;
	assign carry_next.vld  = pass_vld_q;
	assign carry_next.data = pass_data_q;

endmodule
